[design/dcs_pkg.sv]
// Shared types, codes and constants of the dosing cycle sequencer.
// Used by every module of the block; depends on nothing else.
package dcs_pkg;

  // Sequencer phases, in the encoding shown on dosing_state.
  typedef enum logic [2:0] {
    PH_IDLE      = 3'd0,
    PH_REQUESTED = 3'd1,
    PH_PRECOOL   = 3'd2,
    PH_STARTING  = 3'd3,
    PH_RUNNING   = 3'd4,
    PH_STOPPING  = 3'd5,
    PH_FINISHED  = 3'd6,
    PH_ERROR     = 3'd7
  } phase_t;

  // Item kinds. The fourth code carries no request.
  localparam logic [1:0] KIND_STEP  = 2'd0;
  localparam logic [1:0] KIND_START = 2'd1;
  localparam logic [1:0] KIND_STOP  = 2'd2;
  localparam logic [1:0] KIND_NONE  = 2'd3;

  // Error codes.
  localparam logic [3:0] ERR_NONE        = 4'd0;
  localparam logic [3:0] ERR_LINK_WARN   = 4'd1;
  localparam logic [3:0] ERR_CALIB       = 4'd2;
  localparam logic [3:0] ERR_LOGIC       = 4'd3;
  localparam logic [3:0] ERR_TEMP_SENSOR = 4'd4;
  localparam logic [3:0] ERR_PRECOOL_TO  = 4'd5;
  localparam logic [3:0] ERR_DOSING_TO   = 4'd6;
  localparam logic [3:0] ERR_FLOW        = 4'd7;
  localparam logic [3:0] ERR_OTHER       = 4'd8;

  // Register indexes, taken from paddr[4:2].
  localparam int unsigned ADDR_W = 5;
  localparam logic [2:0] REG_TEMP_SETPOINT = 3'd0;
  localparam logic [2:0] REG_MOTOR_SPEED   = 3'd1;
  localparam logic [2:0] REG_FLOW_CAL      = 3'd2;
  localparam logic [2:0] REG_PRECOOL_TO    = 3'd3;
  localparam logic [2:0] REG_MAX_DOSING    = 3'd4;

  // Register reset values.
  localparam logic [11:0] RST_TEMP_SETPOINT = 12'd120;
  localparam logic [31:0] RST_PRECOOL_TO    = 32'd300000;
  localparam logic [31:0] RST_MAX_DOSING    = 32'd900000;

  // Temperature hysteresis in tenths of a degree.
  localparam logic signed [12:0] HYST_TENTHS = 13'sd10;

  // x / 10 == (x * DIV10_MAGIC) >> DIV10_SHIFT, exact for any x below 2**32.
  localparam logic [31:0] DIV10_MAGIC = 32'hCCCC_CCCD;
  localparam int unsigned DIV10_SHIFT = 35;

  typedef struct packed {
    logic signed [11:0] temp_setpoint;
    logic [15:0]        motor_speed;
    logic               flow_calibrated;
    logic [31:0]        precool_limit_ms;
    logic [31:0]        max_dosing_ms;
  } cfg_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic [31:0]        now_ms;
    logic [15:0]        target_volume_ml;
    logic               power_enabled;
    logic               calibration_active;
    logic signed [11:0] temperature;
    logic               temp_valid;
    logic [23:0]        volume_dispensed;
    logic [3:0]         external_error;
    logic               motor_halted;
  } item_t;

  typedef struct packed {
    phase_t      phase;
    logic [31:0] phase_start_ms;
    logic [15:0] target_volume;
    logic [3:0]  latched_error;
    logic        motor_flag;
    logic        compressor_flag;
    logic        flow_check_flag;
    logic [31:0] cycles_done;
    logic [31:0] volume_total;
  } seq_state_t;

  typedef struct packed {
    logic [2:0]  dosing_state;
    logic        motor_on;
    logic        compressor_on;
    logic        flow_check_on;
    logic        clear_volume;
    logic [3:0]  error_code;
    logic [31:0] cycle_count;
    logic [31:0] total_volume_ml;
    logic        save_request;
  } result_t;

endpackage

[design/dcs_csr.sv]
// Configuration registers of the dosing cycle sequencer behind an APB-style port.
// Depends on dcs_pkg.
module dcs_csr (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [dcs_pkg::ADDR_W-1:0]   paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  output dcs_pkg::cfg_t                cfg
);

  logic       wr_en;
  logic [2:0] idx;

  assign pready = 1'b1;
  assign idx    = paddr[4:2];
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.temp_setpoint      <= dcs_pkg::RST_TEMP_SETPOINT;
      cfg.motor_speed        <= 16'd0;
      cfg.flow_calibrated    <= 1'b0;
      cfg.precool_limit_ms   <= dcs_pkg::RST_PRECOOL_TO;
      cfg.max_dosing_ms      <= dcs_pkg::RST_MAX_DOSING;
    end else if (wr_en) begin
      unique case (idx)
        dcs_pkg::REG_TEMP_SETPOINT: cfg.temp_setpoint      <= pwdata[11:0];
        dcs_pkg::REG_MOTOR_SPEED:   cfg.motor_speed        <= pwdata[15:0];
        dcs_pkg::REG_FLOW_CAL:      cfg.flow_calibrated    <= pwdata[0];
        dcs_pkg::REG_PRECOOL_TO:    cfg.precool_limit_ms   <= pwdata;
        dcs_pkg::REG_MAX_DOSING:    cfg.max_dosing_ms      <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      dcs_pkg::REG_TEMP_SETPOINT: prdata = {{20{cfg.temp_setpoint[11]}}, cfg.temp_setpoint};
      dcs_pkg::REG_MOTOR_SPEED:   prdata = {16'd0, cfg.motor_speed};
      dcs_pkg::REG_FLOW_CAL:      prdata = {31'd0, cfg.flow_calibrated};
      dcs_pkg::REG_PRECOOL_TO:    prdata = cfg.precool_limit_ms;
      dcs_pkg::REG_MAX_DOSING:    prdata = cfg.max_dosing_ms;
      default:                    prdata = 32'd0;
    endcase
  end

endmodule

[design/dcs_step.sv]
// Next-state and result logic of the dosing cycle sequencer for one item.
// Purely combinational; depends on dcs_pkg.
module dcs_step (
  input  dcs_pkg::cfg_t       cfg,
  input  dcs_pkg::seq_state_t st,
  input  dcs_pkg::item_t      item,
  output dcs_pkg::seq_state_t nxt,
  output dcs_pkg::result_t    res
);

  logic               busy;
  logic               motor_run;
  logic [3:0]         err;
  logic [31:0]        elapsed;
  logic signed [12:0] temp_x;
  logic signed [12:0] sp_x;
  logic signed [12:0] sp_hi;
  logic [23:0]        vol_goal;
  logic [24:0]        vol_rnd;
  logic [56:0]        prod;
  logic [21:0]        vol_ml;
  logic               clear_pulse;
  logic               save_pulse;

  assign busy = (st.phase != dcs_pkg::PH_IDLE) && (st.phase != dcs_pkg::PH_FINISHED)
                && (st.phase != dcs_pkg::PH_ERROR);
  assign motor_run = st.motor_flag && !item.motor_halted;
  assign elapsed   = item.now_ms - st.phase_start_ms;
  assign temp_x    = 13'(item.temperature);
  assign sp_x      = 13'(cfg.temp_setpoint);
  assign sp_hi     = sp_x + dcs_pkg::HYST_TENTHS;
  // Target in tenths of a millilitre: ten times the target, as shift-adds.
  assign vol_goal  = {5'd0, st.target_volume, 3'd0} + {7'd0, st.target_volume, 1'b0};
  // Rounded millilitres: (volume + 5) / 10 through the reciprocal.
  assign vol_rnd   = {1'b0, item.volume_dispensed} + 25'd5;
  assign prod      = 57'(vol_rnd) * 57'(dcs_pkg::DIV10_MAGIC);
  assign vol_ml    = prod[dcs_pkg::DIV10_SHIFT +: 22];

  // An external error overrides the latched one before the item is handled.
  always_comb begin
    if (item.external_error == dcs_pkg::ERR_NONE) begin
      err = st.latched_error;
    end else if (item.external_error > dcs_pkg::ERR_OTHER) begin
      err = dcs_pkg::ERR_OTHER;
    end else begin
      err = item.external_error;
    end
  end

  always_comb begin
    nxt               = st;
    nxt.latched_error = err;
    clear_pulse       = 1'b0;
    save_pulse        = 1'b0;
    unique case (item.kind)
      dcs_pkg::KIND_START: begin
        priority if (item.calibration_active) begin
          nxt.latched_error = dcs_pkg::ERR_CALIB;
        end else if (!item.power_enabled || busy) begin
          nxt.latched_error = dcs_pkg::ERR_LOGIC;
        end else if (!cfg.flow_calibrated) begin
          nxt.latched_error = dcs_pkg::ERR_CALIB;
        end else begin
          nxt.target_volume  = item.target_volume_ml;
          clear_pulse        = 1'b1;
          nxt.phase          = dcs_pkg::PH_REQUESTED;
          nxt.phase_start_ms = item.now_ms;
          nxt.latched_error  = dcs_pkg::ERR_NONE;
        end
      end
      dcs_pkg::KIND_STOP: begin
        if (motor_run) begin
          nxt.motor_flag      = 1'b0;
          nxt.flow_check_flag = 1'b0;
        end
        if (busy) begin
          nxt.phase          = dcs_pkg::PH_STOPPING;
          nxt.phase_start_ms = item.now_ms;
        end
      end
      dcs_pkg::KIND_STEP: begin
        unique case (st.phase)
          dcs_pkg::PH_IDLE: ;
          dcs_pkg::PH_REQUESTED: begin
            nxt.phase_start_ms = item.now_ms;
            priority if (!item.power_enabled) begin
              nxt.latched_error = dcs_pkg::ERR_LOGIC;
              nxt.phase         = dcs_pkg::PH_IDLE;
            end else if (err == dcs_pkg::ERR_TEMP_SENSOR) begin
              nxt.phase = dcs_pkg::PH_STOPPING;
            end else if (item.temp_valid && (temp_x <= sp_hi)) begin
              nxt.phase = dcs_pkg::PH_STARTING;
            end else begin
              nxt.compressor_flag = 1'b1;
              nxt.phase           = dcs_pkg::PH_PRECOOL;
            end
          end
          dcs_pkg::PH_PRECOOL: begin
            priority if (!item.power_enabled) begin
              nxt.phase          = dcs_pkg::PH_STOPPING;
              nxt.phase_start_ms = item.now_ms;
            end else if ((err == dcs_pkg::ERR_TEMP_SENSOR)
                         || (item.temp_valid && (temp_x <= sp_x))) begin
              nxt.phase          = dcs_pkg::PH_STARTING;
              nxt.phase_start_ms = item.now_ms;
            end else if (elapsed > cfg.precool_limit_ms) begin
              nxt.latched_error  = dcs_pkg::ERR_PRECOOL_TO;
              nxt.phase          = dcs_pkg::PH_STOPPING;
              nxt.phase_start_ms = item.now_ms;
            end else begin
              nxt.compressor_flag = 1'b1;
            end
          end
          dcs_pkg::PH_STARTING: begin
            nxt.phase_start_ms = item.now_ms;
            priority if (!item.power_enabled) begin
              nxt.phase = dcs_pkg::PH_STOPPING;
            end else if (err == dcs_pkg::ERR_TEMP_SENSOR) begin
              nxt.phase = dcs_pkg::PH_ERROR;
            end else if (item.temp_valid && (temp_x > sp_hi)) begin
              nxt.phase = dcs_pkg::PH_PRECOOL;
            end else if (cfg.motor_speed != 16'd0) begin
              clear_pulse         = 1'b1;
              nxt.motor_flag      = 1'b1;
              nxt.flow_check_flag = 1'b1;
              nxt.phase           = dcs_pkg::PH_RUNNING;
            end else begin
              clear_pulse       = 1'b1;
              nxt.latched_error = dcs_pkg::ERR_LOGIC;
              nxt.phase         = dcs_pkg::PH_ERROR;
            end
          end
          dcs_pkg::PH_RUNNING: begin
            priority if (!item.power_enabled || !motor_run
                         || ((err != dcs_pkg::ERR_NONE) && (err != dcs_pkg::ERR_LINK_WARN))
                         || (item.volume_dispensed >= vol_goal)) begin
              nxt.phase          = dcs_pkg::PH_STOPPING;
              nxt.phase_start_ms = item.now_ms;
            end else if (elapsed > cfg.max_dosing_ms) begin
              nxt.latched_error  = dcs_pkg::ERR_DOSING_TO;
              nxt.phase          = dcs_pkg::PH_STOPPING;
              nxt.phase_start_ms = item.now_ms;
            end else begin
            end
          end
          dcs_pkg::PH_STOPPING: begin
            nxt.motor_flag      = 1'b0;
            nxt.compressor_flag = 1'b0;
            nxt.flow_check_flag = 1'b0;
            nxt.phase_start_ms  = item.now_ms;
            // Timeouts, flow faults and link warnings still end the cycle normally.
            if ((err != dcs_pkg::ERR_NONE) && (err != dcs_pkg::ERR_LINK_WARN)
                && (err != dcs_pkg::ERR_PRECOOL_TO) && (err != dcs_pkg::ERR_DOSING_TO)
                && (err != dcs_pkg::ERR_FLOW)) begin
              nxt.phase = dcs_pkg::PH_ERROR;
            end else begin
              nxt.phase = dcs_pkg::PH_FINISHED;
            end
          end
          dcs_pkg::PH_FINISHED: begin
            nxt.cycles_done    = st.cycles_done + 32'd1;
            nxt.volume_total   = st.volume_total + {10'd0, vol_ml};
            save_pulse         = 1'b1;
            nxt.phase          = dcs_pkg::PH_IDLE;
            nxt.phase_start_ms = item.now_ms;
          end
          dcs_pkg::PH_ERROR: begin
            nxt.motor_flag      = 1'b0;
            nxt.compressor_flag = 1'b0;
            nxt.flow_check_flag = 1'b0;
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  always_comb begin
    res.dosing_state    = nxt.phase;
    res.motor_on        = nxt.motor_flag;
    res.compressor_on   = nxt.compressor_flag;
    res.flow_check_on   = nxt.flow_check_flag;
    res.clear_volume    = clear_pulse;
    res.error_code      = nxt.latched_error;
    res.cycle_count     = nxt.cycles_done;
    res.total_volume_ml = nxt.volume_total;
    res.save_request    = save_pulse;
  end

endmodule

[design/dosing_cycle_sequencer.sv]
// Top level of the dosing cycle sequencer: input register, sequencer state,
// result register and configuration port. Depends on dcs_pkg, dcs_csr, dcs_step.
//
//  Channel  | Handshake                 | Moves
//  ---------+---------------------------+-------------------------------------------
//  input    | in_valid / in_ready       | one item: start, stop or sequencer step
//  result   | out_valid / out_ready     | one result per item: state, commands, totals
//  config   | psel/penable/pwrite/pready| register writes and reads, 32-bit data
//
// Every input transfer produces exactly one result transfer. An item is taken into
// the input register, evaluated against the sequencer state and written to the
// result register, so a new item is accepted every clock while the result register
// is empty or being drained. The result becomes valid once it is written to the
// result register, and then waits there for out_ready.
// The only limit on throughput is the result register: while a result waits
// for out_ready, the input register holds one more item and in_ready drops.
// Reset (rst, synchronous) returns the sequencer to idle with zero totals, no
// error and the register defaults; it needs no clearing pass.
module dosing_cycle_sequencer (
  input  logic                        clk,
  input  logic                        rst,
  // Input channel
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [1:0]                  kind,
  input  logic [31:0]                 now_ms,
  input  logic [15:0]                 target_volume_ml,
  input  logic                        power_enabled,
  input  logic                        calibration_active,
  input  logic signed [11:0]          temperature,
  input  logic                        temp_valid,
  input  logic [23:0]                 volume_dispensed,
  input  logic [3:0]                  external_error,
  input  logic                        motor_halted,
  // Result channel
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [2:0]                  dosing_state,
  output logic                        motor_on,
  output logic                        compressor_on,
  output logic                        flow_check_on,
  output logic                        clear_volume,
  output logic [3:0]                  error_code,
  output logic [31:0]                 cycle_count,
  output logic [31:0]                 total_volume_ml,
  output logic                        save_request,
  // Configuration port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [dcs_pkg::ADDR_W-1:0]  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  dcs_pkg::cfg_t       cfg;
  dcs_pkg::item_t      item;
  dcs_pkg::seq_state_t st;
  dcs_pkg::seq_state_t st_next;
  dcs_pkg::result_t    res_next;
  dcs_pkg::result_t    res;
  logic                item_valid;
  logic                advance;

  dcs_csr u_csr (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // The held item moves on whenever the result register is empty or being drained.
  assign advance  = item_valid && (!out_valid || out_ready);
  assign in_ready = !item_valid || advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ready) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item.kind               <= kind;
      item.now_ms             <= now_ms;
      item.target_volume_ml   <= target_volume_ml;
      item.power_enabled      <= power_enabled;
      item.calibration_active <= calibration_active;
      item.temperature        <= temperature;
      item.temp_valid         <= temp_valid;
      item.volume_dispensed   <= volume_dispensed;
      item.external_error     <= external_error;
      item.motor_halted       <= motor_halted;
    end
  end

  dcs_step u_step (
    .cfg  (cfg),
    .st   (st),
    .item (item),
    .nxt  (st_next),
    .res  (res_next)
  );

  // Sequencer state is updated once per item, in the cycle the item is evaluated.
  always_ff @(posedge clk) begin
    if (rst) begin
      st.phase           <= dcs_pkg::PH_IDLE;
      st.phase_start_ms  <= 32'd0;
      st.target_volume   <= 16'd0;
      st.latched_error   <= dcs_pkg::ERR_NONE;
      st.motor_flag      <= 1'b0;
      st.compressor_flag <= 1'b0;
      st.flow_check_flag <= 1'b0;
      st.cycles_done     <= 32'd0;
      st.volume_total    <= 32'd0;
    end else if (advance) begin
      st <= st_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res <= res_next;
    end
  end

  assign dosing_state    = res.dosing_state;
  assign motor_on        = res.motor_on;
  assign compressor_on   = res.compressor_on;
  assign flow_check_on   = res.flow_check_on;
  assign clear_volume    = res.clear_volume;
  assign error_code      = res.error_code;
  assign cycle_count     = res.cycle_count;
  assign total_volume_ml = res.total_volume_ml;
  assign save_request    = res.save_request;

endmodule

[design/dcs_checker.sv]
// Port-level checks of the dosing cycle sequencer, bound to its top level.
// Depends on dcs_pkg and dosing_cycle_sequencer.
module dcs_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  dosing_state,
  input logic        motor_on,
  input logic        clear_volume,
  input logic [31:0] cycle_count,
  input logic        save_request
);

  // A stalled result holds.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(dosing_state) && $stable(cycle_count))
    else $error("result changed while stalled");

  // Totals are saved only when a finished cycle returns to idle.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && save_request |-> dosing_state == dcs_pkg::PH_IDLE)
    else $error("save request outside the return to idle");

  // Clearing the volume and saving totals never come from the same item.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(clear_volume && save_request))
    else $error("clear and save pulses together");

  // The pump is driven only while running or on the way to a stop.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && motor_on |->
      dosing_state == dcs_pkg::PH_RUNNING || dosing_state == dcs_pkg::PH_STOPPING)
    else $error("motor on outside running or stopping");

  // A volume clear goes with a start or with leaving the starting phase.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && clear_volume |->
      dosing_state == dcs_pkg::PH_REQUESTED || dosing_state == dcs_pkg::PH_RUNNING
      || dosing_state == dcs_pkg::PH_ERROR)
    else $error("volume clear in an unexpected phase");

endmodule

bind dosing_cycle_sequencer dcs_checker u_dcs_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .dosing_state (dosing_state),
  .motor_on     (motor_on),
  .clear_volume (clear_volume),
  .cycle_count  (cycle_count),
  .save_request (save_request)
);
